### rtl/hid6kro_pkg.sv
// shared types and constants for the six-key rollover report table
package hid6kro_pkg;

  // default number of key-code slots kept in the table
  localparam int SLOT_COUNT_DEF = 6;

  // number of slot fields carried in each report
  localparam int REPORT_SLOTS = 6;

  // event codes on the mode field
  typedef logic [2:0] mode_t;
  localparam mode_t MODE_PRESS       = 3'd0;
  localparam mode_t MODE_RELEASE     = 3'd1;
  localparam mode_t MODE_SET_MOD     = 3'd2;
  localparam mode_t MODE_CLEAR_MOD   = 3'd3;
  localparam mode_t MODE_RELEASE_ALL = 3'd4;

  typedef logic [7:0] code_t;

endpackage

### rtl/hid6kro_if.sv
// valid/ready channel interfaces for key events and report transactions
interface hid6kro_req_if
  import hid6kro_pkg::*;
  ();
  logic  valid;
  logic  ready;
  mode_t mode;
  code_t key;

  modport source (output valid, output mode, output key, input ready);
  modport sink (input valid, input mode, input key, output ready);
endinterface

interface hid6kro_rsp_if
  import hid6kro_pkg::*;
  ();
  logic  valid;
  logic  ready;
  logic  status;
  logic  changed;
  code_t modifier_out;
  code_t slot0;
  code_t slot1;
  code_t slot2;
  code_t slot3;
  code_t slot4;
  code_t slot5;

  modport source (
    output valid, output status, output changed, output modifier_out,
    output slot0, output slot1, output slot2, output slot3, output slot4,
    output slot5, input ready
  );
  modport sink (
    input valid, input status, input changed, input modifier_out,
    input slot0, input slot1, input slot2, input slot3, input slot4,
    input slot5, output ready
  );
endinterface

### rtl/hid_six_key_rollover_table_unit.sv
// keyboard report table: key-code slots, modifier byte and event sequencer
// Holds SLOT_COUNT key-code slots (code 0 means empty) and one modifier byte,
// both cleared by reset. Each event on req (press, release, set or clear
// modifier bits, release all) gives exactly one transaction on rsp with a
// status bit, a changed bit and the whole report after the event. Press,
// release and release-all walk the slots one per cycle from slot 0 through a
// single shared compare unit, then pass through the apply and finish states,
// where the report is loaded; modifier events and unused codes skip the walk
// and go straight to the apply state. req is ready only while the sequencer is
// idle; a finished report waits in the output register while the next event
// is taken, and the sequencer holds its next report, with req not ready, until
// the previous one has gone. Slot fields with no slot behind them read 0.
module hid_six_key_rollover_table_unit
  import hid6kro_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  hid6kro_req_if.sink       req,
  hid6kro_rsp_if.source     rsp
);

  localparam int IW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SHOWN = (SLOT_COUNT < REPORT_SLOTS) ? SLOT_COUNT : REPORT_SLOTS;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_FINISH
  } state_t;

  state_t        state;
  code_t         slots [SLOT_COUNT];
  code_t         modifier;
  logic [IW-1:0] idx;
  mode_t         cur_mode;
  code_t         cur_key;
  logic          key_hit;
  logic [IW-1:0] key_idx;
  logic          empty_hit;
  logic [IW-1:0] empty_idx;
  logic          status;
  logic          changed;

  // shared compare unit on the slot under the walk
  code_t cur_slot;
  logic  match_key;
  logic  match_empty;

  assign cur_slot    = slots[idx];
  assign match_key   = (cur_slot == cur_key);
  assign match_empty = (cur_slot == 8'd0);

  // report view of the slots, unbacked fields read zero
  code_t view [REPORT_SLOTS];

  always_comb begin
    for (int i = 0; i < REPORT_SLOTS; i++) begin
      view[i] = 8'd0;
    end
    for (int i = 0; i < SHOWN; i++) begin
      view[i] = slots[i];
    end
  end

  assign req.ready = (state == ST_IDLE);

  // sequencer, table state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      modifier  <= 8'd0;
      rsp.valid <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slots[i] <= 8'd0;
      end
    end else begin
      // drop the report once taken, unless a new one is loaded in its place
      if (rsp.valid && rsp.ready && state != ST_FINISH) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            cur_mode  <= req.mode;
            cur_key   <= req.key;
            idx       <= '0;
            key_hit   <= 1'b0;
            empty_hit <= 1'b0;
            key_idx   <= '0;
            empty_idx <= '0;
            status    <= 1'b0;
            changed   <= 1'b0;
            if (req.mode == MODE_PRESS || req.mode == MODE_RELEASE ||
                req.mode == MODE_RELEASE_ALL) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_APPLY;
            end
          end
        end
        ST_SCAN: begin
          // first matching slot and first empty slot, or clear for release all
          if (cur_mode == MODE_RELEASE_ALL) begin
            if (!match_empty) begin
              changed <= 1'b1;
            end
            slots[idx] <= 8'd0;
          end else begin
            if (match_key && !key_hit) begin
              key_hit <= 1'b1;
              key_idx <= idx;
            end
            if (match_empty && !empty_hit) begin
              empty_hit <= 1'b1;
              empty_idx <= idx;
            end
          end
          if (idx == LAST_IDX) begin
            state <= ST_APPLY;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_APPLY: begin
          case (cur_mode)
            MODE_PRESS: begin
              if (key_hit) begin
                status <= 1'b1;
              end else if (empty_hit) begin
                slots[empty_idx] <= cur_key;
                status           <= 1'b1;
                changed          <= 1'b1;
              end
            end
            MODE_RELEASE: begin
              if (key_hit) begin
                status <= 1'b1;
                if (cur_key != 8'd0) begin
                  slots[key_idx] <= 8'd0;
                  changed        <= 1'b1;
                end
              end
            end
            MODE_SET_MOD: begin
              modifier <= modifier | cur_key;
              changed  <= ((modifier | cur_key) != modifier);
            end
            MODE_CLEAR_MOD: begin
              modifier <= modifier & ~cur_key;
              changed  <= ((modifier & ~cur_key) != modifier);
            end
            MODE_RELEASE_ALL: begin
              if (modifier != 8'd0) begin
                changed <= 1'b1;
              end
              modifier <= 8'd0;
            end
            default: begin
            end
          endcase
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          // load the report once the output register is free
          if (!rsp.valid || rsp.ready) begin
            rsp.valid        <= 1'b1;
            rsp.status       <= status;
            rsp.changed      <= changed;
            rsp.modifier_out <= modifier;
            rsp.slot0        <= view[0];
            rsp.slot1        <= view[1];
            rsp.slot2        <= view[2];
            rsp.slot3        <= view[3];
            rsp.slot4        <= view[4];
            rsp.slot5        <= view[5];
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
